// ===== design/swm_pkg.sv =====
package swm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int LEN_W          = 7;
    localparam int ADDR_W         = 3;
    localparam int PDATA_W        = 32;

    localparam logic [LEN_W-1:0]  LEN_RESET         = 7'd3;
    localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;

    typedef struct packed {
        logic insert;
        logic commit;
        logic clear;
    } swm_cmd_t;

    typedef struct packed {
        logic full;
    } swm_stat_t;

endpackage

// ===== design/swm_ctrl.sv =====
module swm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_wr,
    input  swm_pkg::swm_stat_t stat,
    output swm_pkg::swm_cmd_t  cmd
);
    import swm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;
    logic   out_free;
    logic   commit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_CHECK) && stat.full && out_free;
    assign m_tvalid = m_tvalid_reg;

    assign cmd.insert = accept;
    assign cmd.commit = commit;
    assign cmd.clear  = cfg_wr;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!stat.full || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a word taken always moves on to the check step
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CHECK))
        else $error("accepted word did not reach check step");

    // a committed median is offered next cycle
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid_reg)
        else $error("committed median not offered");

    // a window still filling never blocks the input
    a_fill_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) && !stat.full |=> (state_reg == ST_IDLE))
        else $error("filling window stalled input");

endmodule

// ===== design/swm_datapath.sv =====
module swm_datapath
#(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int CNT_W      = $clog2(WINDOW_MAX + 1),
    parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [swm_pkg::DATA_W-1:0] sample,
    input  logic [CNT_W-1:0]           k_eff,
    input  logic [IDX_W-1:0]           mid,
    input  swm_pkg::swm_cmd_t          cmd,
    output swm_pkg::swm_stat_t         stat,
    output logic [swm_pkg::DATA_W-1:0] median
);
    import swm_pkg::*;

    logic [DATA_W-1:0] val_reg [WINDOW_MAX];
    logic [CNT_W-1:0]  age_reg [WINDOW_MAX];
    logic [DATA_W-1:0] ins_val [WINDOW_MAX];
    logic [CNT_W-1:0]  ins_age [WINDOW_MAX];
    logic [DATA_W-1:0] del_val [WINDOW_MAX];
    logic [CNT_W-1:0]  del_age [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] le;
    logic [WINDOW_MAX-1:0] held;
    logic [WINDOW_MAX-1:0] del;
    logic [WINDOW_MAX-1:0] past_del;
    logic [CNT_W-1:0]  fc_reg;
    logic [CNT_W-1:0]  fc_next;
    logic [DATA_W-1:0] median_reg;
    logic [CNT_W-1:0]  oldest_age;

    assign oldest_age = k_eff - CNT_W'(1);
    assign stat.full  = (fc_reg == k_eff);
    assign median     = median_reg;

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            assign held[i] = (CNT_W'(i) < fc_reg);
            assign le[i]   = held[i] && (val_reg[i] <= sample);
            assign del[i]  = held[i] && (age_reg[i] == oldest_age);

            // insertion: cells above the slot shift up by one
            if (i == 0)
            begin : g_first
                assign ins_val[i]  = le[i] ? val_reg[i] : sample;
                assign ins_age[i]  = le[i] ? age_reg[i] + CNT_W'(1) : '0;
                assign past_del[i] = del[i];
            end
            else
            begin : g_rest
                assign ins_val[i]  = le[i] ? val_reg[i] :
                                     (le[i-1] ? sample : val_reg[i-1]);
                assign ins_age[i]  = le[i] ? age_reg[i] + CNT_W'(1) :
                                     (le[i-1] ? '0 : age_reg[i-1] + CNT_W'(1));
                assign past_del[i] = past_del[i-1] | del[i];
            end

            // removal: cells from the oldest one up shift down by one
            if (i == WINDOW_MAX - 1)
            begin : g_last
                assign del_val[i] = val_reg[i];
                assign del_age[i] = age_reg[i];
            end
            else
            begin : g_mid
                assign del_val[i] = past_del[i] ? val_reg[i+1] : val_reg[i];
                assign del_age[i] = past_del[i] ? age_reg[i+1] : age_reg[i];
            end
        end
    endgenerate

    always_comb
    begin
        fc_next = fc_reg;
        if (cmd.clear)
        begin
            fc_next = '0;
        end
        else if (cmd.insert)
        begin
            fc_next = fc_reg + CNT_W'(1);
        end
        else if (cmd.commit)
        begin
            fc_next = fc_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= '0;
        end
        else
        begin
            fc_reg <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            median_reg <= val_reg[mid];
        end
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (cmd.insert)
            begin
                val_reg[j] <= ins_val[j];
                age_reg[j] <= ins_age[j];
            end
            else if (cmd.commit)
            begin
                val_reg[j] <= del_val[j];
                age_reg[j] <= del_age[j];
            end
        end
    end

endmodule

// ===== design/sliding_window_median_top.sv =====
// channel  | direction | signals                      | word
// ---------+-----------+------------------------------+----------------------------
// s        | in        | s_tvalid s_tready s_tdata    | tdata[31:0] sample
// m        | out       | m_tvalid m_tready m_tdata    | tdata[31:0] median
// apb      | in        | psel penable pwrite paddr .. | 0x0 window_length[6:0]
//
// each input word goes through an insert into the sorted cell row, then a check
// step that, once the window is full, reads the median and drops the oldest cell
// the check step waits while a previous median still sits in the output register
// no output until window_length samples are held; a window_length write empties it
// reset clears the fill count and control; window_length returns to 3
module sliding_window_median_top
#(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swm_pkg::DATA_W-1:0]  s_tdata,   // [31:0] sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swm_pkg::DATA_W-1:0]  m_tdata,   // [31:0] median
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]  paddr,
    input  logic [swm_pkg::PDATA_W-1:0] pwdata,
    output logic [swm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             cfg_wr;
    logic [KW-1:0]    len_wide;
    logic [KW-1:0]    k_wide;
    logic [CNT_W-1:0] k_eff;
    logic [IDX_W-1:0] mid;
    swm_cmd_t         cmd;
    swm_stat_t        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_LENGTH);
    assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? PDATA_W'(len_reg) : '0;
    assign len_next = cfg_wr ? pwdata[LEN_W-1:0] : len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // zero acts as one, oversize clamps to the cell count
    assign len_wide = KW'(len_reg);
    always_comb
    begin
        if (len_wide == '0)
        begin
            k_wide = KW'(1);
        end
        else if (len_wide > KW'(WINDOW_MAX))
        begin
            k_wide = KW'(WINDOW_MAX);
        end
        else
        begin
            k_wide = len_wide;
        end
    end

    assign k_eff = k_wide[CNT_W-1:0];
    assign mid   = IDX_W'((k_eff - CNT_W'(1)) >> 1);

    swm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr   (cfg_wr),
        .stat     (stat),
        .cmd      (cmd)
    );

    swm_datapath
    #(
        .WINDOW_MAX (WINDOW_MAX),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (s_tdata),
        .k_eff  (k_eff),
        .mid    (mid),
        .cmd    (cmd),
        .stat   (stat),
        .median (m_tdata)
    );

endmodule
